/* rtl/qtir_pkg.sv */
// qtir_pkg: shared types and codes for the quarter-turn image rotator.
// Used by every other file of the project. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qtir_pkg;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned COORD_W   = 7;
    localparam int unsigned DIM_W     = 8;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned QTR_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [QTR_W-1:0] QTR_0 = 2'd0;
    localparam logic [QTR_W-1:0] QTR_1 = 2'd1;
    localparam logic [QTR_W-1:0] QTR_2 = 2'd2;
    localparam logic [QTR_W-1:0] QTR_3 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 2'd1;

    // Result of mapping one command back to base coordinates.
    typedef struct packed {
        logic [QTR_W-1:0] quarters;  // orientation after the command
        logic [DIM_W-1:0] cw;        // current width
        logic [DIM_W-1:0] ch;        // current height
        logic             err;       // coordinates out of range
        logic             wr;        // in-range write
        logic             rd;        // in-range read
        logic [DIM_W-1:0] bx;        // base column
        logic [DIM_W-1:0] by;        // base row
    } map_t;

    // Status carried alongside the store read.
    typedef struct packed {
        logic [QTR_W-1:0] quarters;
        logic [DIM_W-1:0] cw;
        logic [DIM_W-1:0] ch;
        logic             err;
        logic             rd;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/qtir_map.sv */
// qtir_map: orientation update, range check and current-to-base coordinate map.
// Depends on qtir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qtir_map (
    input  wire logic [qtir_pkg::CMD_W-1:0]   cmd,
    input  wire logic [qtir_pkg::COORD_W-1:0] coord_x,
    input  wire logic [qtir_pkg::COORD_W-1:0] coord_y,
    input  wire logic [qtir_pkg::QTR_W-1:0]   target_quarters,
    input  wire logic [qtir_pkg::QTR_W-1:0]   orient,
    input  wire logic [qtir_pkg::DIM_W-1:0]   base_w,
    input  wire logic [qtir_pkg::DIM_W-1:0]   base_h,
    output qtir_pkg::map_t                    map
);

    logic [qtir_pkg::QTR_W-1:0] q;
    logic [qtir_pkg::DIM_W-1:0] x8;
    logic [qtir_pkg::DIM_W-1:0] y8;
    logic                       access;

    assign x8 = {1'b0, coord_x};
    assign y8 = {1'b0, coord_y};
    assign q  = (cmd == qtir_pkg::CMD_ROTATE) ? target_quarters : orient;
    assign access = (cmd == qtir_pkg::CMD_WRITE) || (cmd == qtir_pkg::CMD_READ);

    always_comb
    begin
        map.quarters = q;
        map.cw       = q[0] ? base_h : base_w;
        map.ch       = q[0] ? base_w : base_h;
        map.err      = access && ((x8 >= map.cw) || (y8 >= map.ch));
        map.wr       = (cmd == qtir_pkg::CMD_WRITE) && !map.err;
        map.rd       = (cmd == qtir_pkg::CMD_READ) && !map.err;
        case (q)
            qtir_pkg::QTR_1:
            begin
                map.bx = y8;
                map.by = base_h - 8'd1 - x8;
            end
            qtir_pkg::QTR_2:
            begin
                map.bx = base_w - 8'd1 - x8;
                map.by = base_h - 8'd1 - y8;
            end
            qtir_pkg::QTR_3:
            begin
                map.bx = base_w - 8'd1 - y8;
                map.by = x8;
            end
            default:
            begin
                map.bx = x8;
                map.by = y8;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/quarter_turn_image_rotator_top.sv */
// quarter_turn_image_rotator_top: pixel store with quarter-turn addressing.
// Depends on qtir_pkg and qtir_map.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel (in_valid / in_stall): one beat per command. cmd selects
//   write pixel, rotate to target orientation, or read pixel. Coordinates are
//   given in the current orientation; the store always keeps the base image.
//   Result channel (out_valid / out_stall): exactly one beat per command,
//   in order: read pixel (zero otherwise), current width, height,
//   orientation and the range error flag.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high. Index 0
//   sets base width, index 1 base height; other indexes are dropped. Values
//   are clamped to 1..MAX on write. Write only while the block is idle.
// Timing
//   A command beat is mapped into the synchronous store port, then goes to
//   the output register as a result beat. Throughput is one command per
//   cycle while out_stall is low, set by the single store port.
// Stall
//   While out_stall holds, the result register holds and one more command is
//   taken into the store stage; then in_stall rises until the result beat goes.
// Reset
//   Orientation returns to zero, both base dimensions to 128 (clamped to the
//   maxima); the pipeline empties. Store contents stay; read only written ones.

module quarter_turn_image_rotator_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             in_valid,
    output      logic                             in_stall,
    input  wire logic [qtir_pkg::CMD_W-1:0]       cmd,
    input  wire logic [qtir_pkg::COORD_W-1:0]     coord_x,
    input  wire logic [qtir_pkg::COORD_W-1:0]     coord_y,
    input  wire logic [qtir_pkg::PIX_W-1:0]       pixel_in,
    input  wire logic [qtir_pkg::QTR_W-1:0]       target_quarters,

    output      logic                             out_valid,
    input  wire logic                             out_stall,
    output      logic [qtir_pkg::PIX_W-1:0]       pixel_out,
    output      logic [qtir_pkg::DIM_W-1:0]       cur_width,
    output      logic [qtir_pkg::DIM_W-1:0]       cur_height,
    output      logic [qtir_pkg::QTR_W-1:0]       cur_quarters,
    output      logic                             range_error,

    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [qtir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [qtir_pkg::DIM_W-1:0]       cfg_data
);

    // Store geometry: row-major in base coordinates, MAX_WIDTH words a row.
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Dimension caps that fit the 8-bit register fields.
    localparam int W_CAP = (MAX_WIDTH  > 255) ? 255 : MAX_WIDTH;
    localparam int H_CAP = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
    localparam logic [qtir_pkg::DIM_W-1:0] W_CAP8 = qtir_pkg::DIM_W'(W_CAP);
    localparam logic [qtir_pkg::DIM_W-1:0] H_CAP8 = qtir_pkg::DIM_W'(H_CAP);
    localparam logic [qtir_pkg::DIM_W-1:0] W_RST  = (W_CAP < 128) ? W_CAP8 : 8'd128;
    localparam logic [qtir_pkg::DIM_W-1:0] H_RST  = (H_CAP < 128) ? H_CAP8 : 8'd128;

    // Config registers, stored already clamped.
    logic [qtir_pkg::DIM_W-1:0] base_w_reg;
    logic [qtir_pkg::DIM_W-1:0] base_h_reg;
    logic [qtir_pkg::DIM_W-1:0] cfg_w_next;
    logic [qtir_pkg::DIM_W-1:0] cfg_h_next;

    logic [qtir_pkg::QTR_W-1:0] orient_reg;

    // Store stage.
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    qtir_pkg::stat_t            s1_stat_reg;
    logic [qtir_pkg::PIX_W-1:0] rd_data_reg;

    // Result register.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [qtir_pkg::PIX_W-1:0] pixel_out_reg;
    qtir_pkg::stat_t            out_stat_reg;

    logic [qtir_pkg::PIX_W-1:0] store_mem [DEPTH];

    qtir_pkg::map_t             map;
    logic [31:0]                addr_full;
    logic [ADDR_W-1:0]          addr;
    logic                       addr_ok;
    logic                       accept;
    logic                       out_load;
    logic                       s1_move;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data == 8'd0)
            cfg_w_next = 8'd1;
        else if (cfg_data > W_CAP8)
            cfg_w_next = W_CAP8;
        else
            cfg_w_next = cfg_data;

        if (cfg_data == 8'd0)
            cfg_h_next = 8'd1;
        else if (cfg_data > H_CAP8)
            cfg_h_next = H_CAP8;
        else
            cfg_h_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_w_reg <= W_RST;
            base_h_reg <= H_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == qtir_pkg::REG_BASE_WIDTH)
                base_w_reg <= cfg_w_next;
            else if (cfg_index == qtir_pkg::REG_BASE_HEIGHT)
                base_h_reg <= cfg_h_next;
        end
    end

    qtir_map u_map (
        .cmd             (cmd),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .target_quarters (target_quarters),
        .orient          (orient_reg),
        .base_w          (base_w_reg),
        .base_h          (base_h_reg),
        .map             (map)
    );

    // Row-major address; the row scale is a constant multiply.
    assign addr_full = 32'(map.by) * 32'(MAX_WIDTH) + 32'(map.bx);
    assign addr      = addr_full[ADDR_W-1:0];
    assign addr_ok   = (addr_full < 32'(DEPTH));

    // Handshake: result register loads when empty or taken; store stage
    // drains into it; a new command enters when the store stage frees up.
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg    <= qtir_pkg::QTR_0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                orient_reg <= map.quarters;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Store port: on each accepted beat, a write if in range and a read of the addressed word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (map.wr && addr_ok)
                store_mem[addr] <= pixel_in;
            rd_data_reg <= store_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_stat_reg.quarters <= map.quarters;
            s1_stat_reg.cw       <= map.cw;
            s1_stat_reg.ch       <= map.ch;
            s1_stat_reg.err      <= map.err;
            s1_stat_reg.rd       <= map.rd && addr_ok;
        end
        if (s1_move)
        begin
            out_stat_reg  <= s1_stat_reg;
            pixel_out_reg <= s1_stat_reg.rd ? rd_data_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign cur_width    = out_stat_reg.cw;
    assign cur_height   = out_stat_reg.ch;
    assign cur_quarters = out_stat_reg.quarters;
    assign range_error  = out_stat_reg.err;

endmodule

`default_nettype wire

/* rtl/qtir_checker.sv */
// qtir_checker: port-level assertions for quarter_turn_image_rotator_top.
// Depends on qtir_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module qtir_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [qtir_pkg::PIX_W-1:0]   pixel_out,
    input wire logic [qtir_pkg::DIM_W-1:0]   cur_width,
    input wire logic [qtir_pkg::DIM_W-1:0]   cur_height,
    input wire logic                         range_error
);

    // A stalled result beat stays.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled pixel holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel_out))
        else $error("pixel changed while stalled");

    // An out-of-range access returns no pixel data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> pixel_out == '0)
        else $error("pixel returned with range error");

    // Reported dimensions come from clamped registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cur_width != '0) && (cur_height != '0))
        else $error("zero dimension reported");

endmodule

bind quarter_turn_image_rotator_top qtir_checker u_qtir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .cur_width   (cur_width),
    .cur_height  (cur_height),
    .range_error (range_error)
);

`default_nettype wire

/* tb/rotator_checker.sv */
// rotator_checker: watches the command, result and register channels of the
// quarter-turn image rotator, predicts every result beat and compares it.
// Depends on qtir_pkg.
`timescale 1ns / 1ps

module rotator_checker #(
    parameter int MAX_W = 128,
    parameter int MAX_H = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [qtir_pkg::CMD_W-1:0]       cmd,
    input  logic [qtir_pkg::COORD_W-1:0]     coord_x,
    input  logic [qtir_pkg::COORD_W-1:0]     coord_y,
    input  logic [qtir_pkg::PIX_W-1:0]       pixel_in,
    input  logic [qtir_pkg::QTR_W-1:0]       target_quarters,

    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [qtir_pkg::PIX_W-1:0]       pixel_out,
    input  logic [qtir_pkg::DIM_W-1:0]       cur_width,
    input  logic [qtir_pkg::DIM_W-1:0]       cur_height,
    input  logic [qtir_pkg::QTR_W-1:0]       cur_quarters,
    input  logic                             range_error,

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [qtir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qtir_pkg::DIM_W-1:0]       cfg_data,

    output int                               mismatch_count,
    output int                               results_pending
);
    import qtir_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [DIM_W-1:0] cw;
        logic [DIM_W-1:0] ch;
        logic [QTR_W-1:0] quarters;
        logic             err;
    } rot_result_t;

    logic [PIX_W-1:0] pixel_shadow [MAX_W*MAX_H];
    logic [DIM_W-1:0] base_w;
    logic [DIM_W-1:0] base_h;
    logic [QTR_W-1:0] orient;
    rot_result_t      expected_results [$];
    rot_result_t      want;
    int               tally = 0;

    // register values are kept raw; 0 reads as 1, above the maximum as the maximum
    function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v, input int lim);
        if (v == '0)
            return DIM_W'(1);
        if (int'(v) > lim)
            return DIM_W'(lim);
        return v;
    endfunction

    // applies one command to the shadow state and returns the beat it must produce
    function automatic rot_result_t predict_command(
        input logic [CMD_W-1:0]   c,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [PIX_W-1:0]   pin,
        input logic [QTR_W-1:0]   tq
    );
        rot_result_t      r;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] bx;
        logic [DIM_W-1:0] by;
        int               addr;
        w = fit_dim(base_w, MAX_W);
        h = fit_dim(base_h, MAX_H);
        if (c == CMD_ROTATE)
            orient = tq;
        r.quarters = orient;
        r.cw       = orient[0] ? h : w;
        r.ch       = orient[0] ? w : h;
        r.pixel    = '0;
        r.err      = 1'b0;
        if (c == CMD_WRITE || c == CMD_READ)
        begin
            if ({1'b0, x} >= r.cw || {1'b0, y} >= r.ch)
                r.err = 1'b1;
            else
            begin
                case (orient)
                    QTR_1:
                    begin
                        bx = {1'b0, y};
                        by = h - DIM_W'(1) - {1'b0, x};
                    end
                    QTR_2:
                    begin
                        bx = w - DIM_W'(1) - {1'b0, x};
                        by = h - DIM_W'(1) - {1'b0, y};
                    end
                    QTR_3:
                    begin
                        bx = w - DIM_W'(1) - {1'b0, y};
                        by = {1'b0, x};
                    end
                    default:
                    begin
                        bx = {1'b0, x};
                        by = {1'b0, y};
                    end
                endcase
                addr = int'(by) * MAX_W + int'(bx);
                if (c == CMD_WRITE)
                    pixel_shadow[addr] = pin;
                else
                    r.pixel = pixel_shadow[addr];
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string fname, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            if (tally < 10)
                $display("%0t: %s mismatch, expected %h got %h", $realtime, fname,
                         exp_v, act_v);
            tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient = QTR_0;
            base_w = DIM_W'(128);
            base_h = DIM_W'(128);
            expected_results.delete();
            results_pending <= 0;
            mismatch_count  <= tally;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (tally < 10)
                        $display("%0t: result beat with no command pending", $realtime);
                    tally++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("pixel_out", want.pixel, pixel_out);
                    compare_field("cur_width", 32'(want.cw), 32'(cur_width));
                    compare_field("cur_height", 32'(want.ch), 32'(cur_height));
                    compare_field("cur_quarters", 32'(want.quarters), 32'(cur_quarters));
                    compare_field("range_error", 32'(want.err), 32'(range_error));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BASE_WIDTH:  base_w = cfg_data;
                    REG_BASE_HEIGHT: base_h = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_command(cmd, coord_x, coord_y,
                                                           pixel_in, target_quarters));
            results_pending <= expected_results.size();
            mismatch_count  <= tally;
        end
    end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for quarter_turn_image_rotator_top, with
// rotator_checker doing prediction and comparison. Depends on qtir_pkg.
`timescale 1ns / 1ps

module tb;
    import qtir_pkg::*;

    localparam int MAX_W        = 128;
    localparam int MAX_H        = 128;
    localparam int IDLE_PCT     = 35;   // chance per cycle that a side holds off
    localparam int DRAIN_CYCLES = 4;    // margin after the last pending result
    localparam int TAIL_CYCLES  = 10;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;

    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [PIX_W-1:0]     pixel_in;
    logic [QTR_W-1:0]     target_quarters;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     pixel_out;
    logic [DIM_W-1:0]     cur_width;
    logic [DIM_W-1:0]     cur_height;
    logic [QTR_W-1:0]     cur_quarters;
    logic                 range_error;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    int                   mismatch_count;
    int                   results_pending;

    // When set, neither side holds off: one long back-to-back stretch.
    bit                   calm;

    // Stimulus-side view of the block, kept only to aim reads at written
    // pixels and to place writes inside the image. Checking lives elsewhere.
    int                   w_eff = MAX_W;
    int                   h_eff = MAX_H;
    logic [QTR_W-1:0]     orient_tx;
    bit                   written [MAX_W*MAX_H];
    int                   written_list [$];

    int n_items, n_writes, n_reads, n_rotates, n_oob, n_unused, n_cfg, n_settings;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quarter_turn_image_rotator_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (.*);

    rotator_checker #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H)
    ) u_checker (.*);

    // Result side back-pressure, random except in the calm stretch.
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    function automatic int fit_dim(input int v, input int lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int cur_w();
        return orient_tx[0] ? h_eff : w_eff;
    endfunction

    function automatic int cur_h();
        return orient_tx[0] ? w_eff : h_eff;
    endfunction

    // Inverse of the block's address map: base pixel -> coordinates as seen
    // in the present orientation.
    task automatic base_to_view(input int bx, input int by,
                                output logic [COORD_W-1:0] x,
                                output logic [COORD_W-1:0] y);
        case (orient_tx)
            QTR_1:
            begin
                x = COORD_W'(h_eff - 1 - by);
                y = COORD_W'(bx);
            end
            QTR_2:
            begin
                x = COORD_W'(w_eff - 1 - bx);
                y = COORD_W'(h_eff - 1 - by);
            end
            QTR_3:
            begin
                x = COORD_W'(by);
                y = COORD_W'(w_eff - 1 - bx);
            end
            default:
            begin
                x = COORD_W'(bx);
                y = COORD_W'(by);
            end
        endcase
    endtask

    // One command beat. Random hold-off first, then the payload stays put
    // until the edge where in_stall is seen low.
    task automatic send_cmd(input logic [CMD_W-1:0]   c,
                            input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y,
                            input logic [PIX_W-1:0]   pin,
                            input logic [QTR_W-1:0]   tq);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= c;
        coord_x         <= x;
        coord_y         <= y;
        pixel_in        <= pin;
        target_quarters <= tq;
        do
            @(posedge clk);
        while (in_stall);
        n_items++;
    endtask

    task automatic write_base(input int bx, input int by, input logic [PIX_W-1:0] pin);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        int                 addr;
        base_to_view(bx, by, x, y);
        addr = by * MAX_W + bx;
        if (!written[addr])
        begin
            written[addr] = 1'b1;
            written_list.push_back(addr);
        end
        n_writes++;
        send_cmd(CMD_WRITE, x, y, pin, QTR_W'($urandom));
    endtask

    // only ever called on pixels already written
    task automatic read_base(input int bx, input int by);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        base_to_view(bx, by, x, y);
        n_reads++;
        send_cmd(CMD_READ, x, y, $urandom, QTR_W'($urandom));
    endtask

    task automatic turn_view(input logic [QTR_W-1:0] t);
        orient_tx = t;
        n_rotates++;
        send_cmd(CMD_ROTATE, COORD_W'($urandom), COORD_W'($urandom), $urandom, t);
    endtask

    task automatic send_oob(input logic [CMD_W-1:0] c, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y);
        n_oob++;
        send_cmd(c, x, y, $urandom, QTR_W'($urandom));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        n_cfg++;
    endtask

    // New base size: drain every pending result first so the block is idle.
    // Writes to the unused indexes ride along now and then.
    task automatic set_base_dims(input int wr, input int hr, input bit spare);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write(REG_BASE_WIDTH, DIM_W'(wr));
        cfg_write(REG_BASE_HEIGHT, DIM_W'(hr));
        if (spare)
        begin
            cfg_write(REG_SPARE_2, DIM_W'($urandom));
            cfg_write(REG_SPARE_3, DIM_W'($urandom));
        end
        cfg_valid <= 1'b0;
        w_eff = fit_dim(wr, MAX_W);
        h_eff = fit_dim(hr, MAX_H);
        n_settings++;
    endtask

    // Mix: writes, reads of written pixels, rotates, out-of-range accesses
    // and a few unused commands. Anything that cannot be made here falls
    // back to an in-range write.
    task automatic random_item();
        int                 pick;
        int                 cw;
        int                 ch;
        int                 addr;
        int                 tries;
        bit                 done;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        cw   = cur_w();
        ch   = cur_h();
        done = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick >= 35 && pick < 65)
        begin
            for (tries = 0; tries < 8 && !done && written_list.size() > 0; tries++)
            begin
                addr = written_list[$urandom_range(0, written_list.size() - 1)];
                if (addr % MAX_W < w_eff && addr / MAX_W < h_eff)
                begin
                    read_base(addr % MAX_W, addr / MAX_W);
                    done = 1'b1;
                end
            end
        end
        else if (pick >= 65 && pick < 75)
        begin
            turn_view(QTR_W'($urandom));
            done = 1'b1;
        end
        else if (pick >= 75 && pick < 90 && (cw < MAX_W || ch < MAX_H))
        begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
            if (cw < MAX_W && (ch == MAX_H || $urandom_range(0, 1) == 1))
                x = COORD_W'($urandom_range(cw, MAX_W - 1));
            else
                y = COORD_W'($urandom_range(ch, MAX_H - 1));
            send_oob($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, x, y);
            done = 1'b1;
        end
        else if (pick >= 90 && pick < 95)
        begin
            n_unused++;
            send_cmd(CMD_UNUSED, COORD_W'($urandom), COORD_W'($urandom), $urandom,
                     QTR_W'($urandom));
            done = 1'b1;
        end
        if (!done)
            write_base($urandom_range(0, w_eff - 1), $urandom_range(0, h_eff - 1), $urandom);
    endtask

    task automatic random_items(input int count);
        repeat (count) random_item();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        cmd             <= CMD_WRITE;
        coord_x         <= '0;
        coord_y         <= '0;
        pixel_in        <= '0;
        target_quarters <= QTR_0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_BASE_WIDTH;
        cfg_data        <= '0;
        calm            = 1'b0;
        orient_tx       = QTR_0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full 128x128 image from reset: corners, each orientation, the
        // unused command with every bit set.
        write_base(0, 0, 32'hFFFF_FFFF);
        write_base(MAX_W - 1, MAX_H - 1, 32'h0000_0000);
        write_base(MAX_W - 1, 0, 32'hA5A5_A5A5);
        write_base(0, MAX_H - 1, 32'h5A5A_5A5A);
        read_base(0, 0);
        read_base(MAX_W - 1, MAX_H - 1);
        turn_view(QTR_1);
        read_base(MAX_W - 1, 0);
        write_base(64, 3, $urandom);
        turn_view(QTR_2);
        read_base(0, MAX_H - 1);
        read_base(64, 3);
        turn_view(QTR_3);
        read_base(MAX_W - 1, MAX_H - 1);
        read_base(0, 0);
        turn_view(QTR_0);
        n_unused++;
        send_cmd(CMD_UNUSED, '1, '1, '1, '1);

        // Width register 0 reads as 1, height 255 as the maximum. A one-pixel
        // wide image makes range errors easy to hit on both axes.
        set_base_dims(0, 255, 1'b1);
        send_oob(CMD_WRITE, 7'd127, 7'd0);
        send_oob(CMD_READ, 7'd1, 7'd127);
        read_base(0, MAX_H - 1);
        turn_view(QTR_1);
        send_oob(CMD_READ, 7'd0, 7'd1);
        read_base(0, 0);
        turn_view(QTR_3);
        read_base(0, MAX_H - 1);
        random_items(40);

        set_base_dims(MAX_W, MAX_H, 1'b0);
        random_items(70);

        set_base_dims(1, 1, 1'b1);
        random_items(30);

        // back-to-back stretch, no hold-off on either side
        calm = 1'b1;
        set_base_dims(200, 3, 1'b0);
        random_items(60);
        calm = 1'b0;

        set_base_dims(5, MAX_H, 1'b1);
        random_items(60);

        set_base_dims(17, 9, 1'b0);
        random_items(60);

        set_base_dims($urandom_range(1, 16), $urandom_range(1, 16), 1'b1);
        random_items(50);

        set_base_dims(255, 0, 1'b0);
        random_items(30);

        // let the last results out, then a short tail for stray beats
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d commands: %0d writes, %0d reads, %0d rotates,",
                 n_items, n_writes, n_reads, n_rotates);
        $display("%0d out of range, %0d unused; %0d register beats over %0d image sizes",
                 n_oob, n_unused, n_cfg, n_settings);
        if (mismatch_count == 0)
            $display("quarter_turn_image_rotator_top regression: pass");
        else
            $display("quarter_turn_image_rotator_top regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still pending", results_pending);
        $display("quarter_turn_image_rotator_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/qtir_pkg.sv
rtl/qtir_map.sv
rtl/quarter_turn_image_rotator_top.sv
rtl/qtir_checker.sv
tb/rotator_checker.sv
tb/tb.sv
